[sv/cmtfr_pkg.sv]
// Shared widths, register indexes, reset values and the microcode program of the ranker.
package cmtfr_pkg;

    localparam int MAX_CLASSES = 64;
    localparam int LABEL_W     = $clog2(MAX_CLASSES);
    localparam int RANK_W      = $clog2(MAX_CLASSES);
    localparam int COL_W       = 12;
    localparam int BSIZE_W     = 7;
    localparam int WIDTH_W     = 13;
    localparam int COUNT_W     = 7;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 13;
    localparam int PC_W        = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLASS_COUNT = 2'd2;

    localparam logic [BSIZE_W-1:0] BLOCK_SIZE_RST  = 7'd8;
    localparam logic [WIDTH_W-1:0] IMAGE_WIDTH_RST = 13'd512;
    localparam logic [COUNT_W-1:0] CLASS_COUNT_RST = 7'd64;

    // Which reference label the move-to-front unit works on in a step.
    typedef enum logic [1:0] {
        SEL_REF2,
        SEL_REF1,
        SEL_REF0
    } ref_sel_t;

    // When a step is the last one of an item and loads the result register.
    typedef enum logic [1:0] {
        FIN_NEVER,
        FIN_TOP,
        FIN_ALWAYS
    } fin_cond_t;

    typedef struct packed {
        ref_sel_t        sel;
        fin_cond_t       fin;
        logic [PC_W-1:0] next_pc;
    } ctrl_word_t;

    // The program: three move-to-front steps. In the top row all three references
    // are the same label, so the item finishes after the first step.
    function automatic ctrl_word_t ucode(input logic [PC_W-1:0] pc);
        ctrl_word_t w;
        case (pc)
            2'd0:    w = '{sel: SEL_REF2, fin: FIN_TOP,    next_pc: 2'd1};
            2'd1:    w = '{sel: SEL_REF1, fin: FIN_NEVER,  next_pc: 2'd2};
            2'd2:    w = '{sel: SEL_REF0, fin: FIN_ALWAYS, next_pc: 2'd0};
            default: w = '{sel: SEL_REF0, fin: FIN_ALWAYS, next_pc: 2'd0};
        endcase
        return w;
    endfunction

endpackage

[sv/context_move_to_front_ranker.sv]
// Top level of the context move-to-front ranker: rank table, reference selection and sequencer.
//
// The block keeps a rank for each of 64 class labels, identity after reset. For each
// input beat it picks up to three reference labels from the up, left and up-right
// neighbours (with the top-row, left-edge and right-edge rules, and a reorder when the
// left and up-right references match), moves them to the front in the order reference 2,
// reference 1, reference 0, and returns the rank of coded_label after those moves as one
// output beat. A small microcode ROM steps a single move-to-front unit, one move per
// clock, except that the last move waits while the output beat is still untaken; that
// unit compares and increments all 64 rank registers in parallel. After the input beat is
// accepted the three moves run in turn, and in the top row, where the three references
// coincide, only one move runs before the result is loaded. A new input beat is taken as
// soon as the last move of the previous item has loaded the output register, even while
// that output beat is still waiting for m_ready. The configuration registers (block_size,
// image_width, class_count at indexes 0, 1 and 2; other indexes are ignored) are meant
// to be written only while the block is idle.
module context_move_to_front_ranker (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               cfg_wr_en,
    input  logic [cmtfr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cmtfr_pkg::CFG_DATA_W-1:0]   cfg_wr_data,

    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [cmtfr_pkg::LABEL_W-1:0]      s_label_up,
    input  logic [cmtfr_pkg::LABEL_W-1:0]      s_label_left,
    input  logic [cmtfr_pkg::LABEL_W-1:0]      s_label_up_right,
    input  logic [cmtfr_pkg::COL_W-1:0]        s_block_col,
    input  logic                               s_top_row,
    input  logic [cmtfr_pkg::LABEL_W-1:0]      s_coded_label,

    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [cmtfr_pkg::RANK_W-1:0]       m_coded_rank
);

    // Configuration registers.
    logic [cmtfr_pkg::BSIZE_W-1:0]  block_size_reg;
    logic [cmtfr_pkg::WIDTH_W-1:0]  image_width_reg;
    logic [cmtfr_pkg::COUNT_W-1:0]  class_count_reg;

    // The rank table lives in flip-flops, since every move updates all entries at once.
    logic [cmtfr_pkg::RANK_W-1:0]   rank_reg  [cmtfr_pkg::MAX_CLASSES];
    logic [cmtfr_pkg::RANK_W-1:0]   rank_next [cmtfr_pkg::MAX_CLASSES];

    // Sequencer state.
    logic                           busy_reg;
    logic [cmtfr_pkg::PC_W-1:0]     pc_reg;

    // The current item, with its references already selected.
    logic [cmtfr_pkg::LABEL_W-1:0]  ref0_reg, ref1_reg, ref2_reg;
    logic [cmtfr_pkg::LABEL_W-1:0]  ref0_next, ref1_next, ref2_next;
    logic [cmtfr_pkg::LABEL_W-1:0]  coded_reg;
    logic                           top_reg;

    // Output register.
    logic                           m_valid_reg;
    logic [cmtfr_pkg::RANK_W-1:0]   m_rank_reg;
    logic [cmtfr_pkg::RANK_W-1:0]   m_rank_next;

    cmtfr_pkg::ctrl_word_t          ctrl;
    logic [cmtfr_pkg::LABEL_W-1:0]  mtf_label;
    logic [cmtfr_pkg::RANK_W-1:0]   mtf_rank;
    logic                           step_final;
    logic                           step_go;
    logic                           out_free;
    logic                           s_accept;
    logic [cmtfr_pkg::WIDTH_W-1:0]  edge_sum;
    logic                           right_edge;
    logic [cmtfr_pkg::LABEL_W-1:0]  sel0, sel1, sel2;

    assign s_ready      = !busy_reg;
    assign s_accept     = s_valid && s_ready;
    assign m_valid      = m_valid_reg;
    assign m_coded_rank = m_rank_reg;

    // Reference selection happens on the accepted beat, so the moves only see labels.
    always_comb begin
        edge_sum   = {1'b0, s_block_col} +
                     {{(cmtfr_pkg::WIDTH_W - cmtfr_pkg::BSIZE_W){1'b0}}, block_size_reg};
        right_edge = (edge_sum >= image_width_reg);
        if (s_top_row) begin
            sel0 = (s_block_col == '0) ? '0 : s_label_left;
            sel1 = sel0;
            sel2 = sel0;
        end else begin
            sel0 = s_label_up;
            sel1 = (s_block_col == '0) ? s_label_up : s_label_left;
            sel2 = right_edge ? s_label_up : s_label_up_right;
        end
        // When the left and up-right references agree, that label goes last and the
        // up label is moved first.
        if (!s_top_row && (sel1 == sel2)) begin
            ref0_next = sel1;
            ref1_next = sel1;
            ref2_next = sel0;
        end else begin
            ref0_next = sel0;
            ref1_next = sel1;
            ref2_next = sel2;
        end
    end

    // Decode of the current control word.
    always_comb begin
        ctrl = cmtfr_pkg::ucode(pc_reg);
        case (ctrl.sel)
            cmtfr_pkg::SEL_REF2: mtf_label = ref2_reg;
            cmtfr_pkg::SEL_REF1: mtf_label = ref1_reg;
            cmtfr_pkg::SEL_REF0: mtf_label = ref0_reg;
            default:             mtf_label = ref0_reg;
        endcase
        case (ctrl.fin)
            cmtfr_pkg::FIN_NEVER:  step_final = 1'b0;
            cmtfr_pkg::FIN_TOP:    step_final = top_reg;
            cmtfr_pkg::FIN_ALWAYS: step_final = 1'b1;
            default:               step_final = 1'b1;
        endcase
        // The last step writes the output register, so it waits for it to be free.
        out_free = !m_valid_reg || m_ready;
        step_go  = busy_reg && (!step_final || out_free);
    end

    // Move-to-front unit. Every counted rank below the moved label's rank goes up by
    // one and the moved label drops to rank zero. A label already at rank zero leaves
    // the table as it is, which these rules give without a special case. Labels at or
    // above class_count are outside the scan but still drop to zero when moved.
    always_comb begin
        mtf_rank = rank_reg[mtf_label];
        for (int i = 0; i < cmtfr_pkg::MAX_CLASSES; i++) begin
            if (cmtfr_pkg::LABEL_W'(i) == mtf_label) begin
                rank_next[i] = '0;
            end else if ((cmtfr_pkg::COUNT_W'(i) < class_count_reg) &&
                         (rank_reg[i] < mtf_rank)) begin
                rank_next[i] = rank_reg[i] + 1'b1;
            end else begin
                rank_next[i] = rank_reg[i];
            end
        end
        m_rank_next = rank_next[coded_reg];
    end

    // Control state, configuration and the rank table.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_size_reg  <= cmtfr_pkg::BLOCK_SIZE_RST;
            image_width_reg <= cmtfr_pkg::IMAGE_WIDTH_RST;
            class_count_reg <= cmtfr_pkg::CLASS_COUNT_RST;
            busy_reg        <= 1'b0;
            pc_reg          <= '0;
            m_valid_reg     <= 1'b0;
            for (int i = 0; i < cmtfr_pkg::MAX_CLASSES; i++) begin
                rank_reg[i] <= cmtfr_pkg::RANK_W'(i);
            end
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    cmtfr_pkg::CFG_BLOCK_SIZE:
                        block_size_reg  <= cfg_wr_data[cmtfr_pkg::BSIZE_W-1:0];
                    cmtfr_pkg::CFG_IMAGE_WIDTH:
                        image_width_reg <= cfg_wr_data[cmtfr_pkg::WIDTH_W-1:0];
                    cmtfr_pkg::CFG_CLASS_COUNT:
                        class_count_reg <= cfg_wr_data[cmtfr_pkg::COUNT_W-1:0];
                    default: ;
                endcase
            end

            if (s_accept) begin
                busy_reg <= 1'b1;
                pc_reg   <= '0;
            end else if (step_go) begin
                rank_reg <= rank_next;
                if (step_final) begin
                    busy_reg <= 1'b0;
                    pc_reg   <= '0;
                end else begin
                    pc_reg   <= ctrl.next_pc;
                end
            end

            if (step_go && step_final) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            ref0_reg  <= ref0_next;
            ref1_reg  <= ref1_next;
            ref2_reg  <= ref2_next;
            coded_reg <= s_coded_label;
            top_reg   <= s_top_row;
        end
        if (step_go && step_final) begin
            m_rank_reg <= m_rank_next;
        end
    end

endmodule

[sv/cmtfr_checker.sv]
// Port-level checker for the ranker and the bind that attaches it to the top level.
module cmtfr_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               cfg_wr_en,
    input logic [cmtfr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input logic [cmtfr_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    input logic                               s_valid,
    input logic                               s_ready,
    input logic [cmtfr_pkg::LABEL_W-1:0]      s_label_up,
    input logic [cmtfr_pkg::LABEL_W-1:0]      s_label_left,
    input logic [cmtfr_pkg::LABEL_W-1:0]      s_label_up_right,
    input logic [cmtfr_pkg::COL_W-1:0]        s_block_col,
    input logic                               s_top_row,
    input logic [cmtfr_pkg::LABEL_W-1:0]      s_coded_label,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic [cmtfr_pkg::RANK_W-1:0]       m_coded_rank
);

    // A stalled result beat holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_coded_rank))
        else $error("result beat changed while stalled");

    // At least one move runs after an input beat, so the block is busy next cycle.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken again right after a beat");

    // A new result appears exactly when the sequencer finishes and frees the input.
    a_result_frees_input: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> s_ready && $past(!s_ready))
        else $error("result appeared without a finished item");

    // Reset leaves the block empty and ready.
    a_reset_state: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid && s_ready)
        else $error("block not empty after reset");

endmodule

bind context_move_to_front_ranker cmtfr_checker u_cmtfr_checker (.*);
